// File: src/rrd_pkg.sv
package rrd_pkg;

    localparam int SQ_ST     = 16;
    localparam int DV_ST     = 16;
    localparam int ETA_ST    = 16;
    localparam int UNIT_LAT  = 38;
    localparam int BACK_LAT  = 29;
    localparam int PIPE_LAT  = UNIT_LAT + BACK_LAT;
    localparam int ETA_DLY   = UNIT_LAT - ETA_ST - 2;

    localparam logic [20:0] ETA_MAX = 21'h10_0000;

    typedef logic [2:0][31:0] t_vec;

    // restoring square root, two result bits per stage
    typedef struct packed {
        logic [63:0] x;
        logic [33:0] r;
        logic [31:0] q;
    } t_sq;

    // three lane long division for the unit components
    typedef struct packed {
        t_vec        rem;
        t_vec        nl;
        t_vec        q;
        logic [31:0] len;
        logic [2:0]  sgn;
        logic        zero;
    } t_dv;

    // index ratio division
    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] n;
        logic [31:0] q;
        logic [15:0] ito;
    } t_ed;

    function automatic t_sq sqrt_step(input t_sq s);
        t_sq         o;
        logic [35:0] rn;
        logic [35:0] tr;
        rn  = {s.r, s.x[63:62]};
        tr  = {2'b00, s.q, 2'b01};
        o.x = {s.x[61:0], 2'b00};
        if (rn >= tr) begin
            o.r = 34'(rn - tr);
            o.q = {s.q[30:0], 1'b1};
        end else begin
            o.r = rn[33:0];
            o.q = {s.q[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_dv div_step(input t_dv s);
        t_dv         o;
        logic [32:0] rn;
        o = s;
        for (int i = 0; i < 3; i++) begin
            rn       = {s.rem[i], s.nl[i][31]};
            o.nl[i]  = {s.nl[i][30:0], 1'b0};
            if (rn >= {1'b0, s.len}) begin
                o.rem[i] = 32'(rn - {1'b0, s.len});
                o.q[i]   = {s.q[i][30:0], 1'b1};
            end else begin
                o.rem[i] = rn[31:0];
                o.q[i]   = {s.q[i][30:0], 1'b0};
            end
        end
        return o;
    endfunction

    function automatic t_ed eta_step(input t_ed s);
        t_ed         o;
        logic [16:0] rn;
        o   = s;
        rn  = {s.rem, s.n[31]};
        o.n = {s.n[30:0], 1'b0};
        if (rn >= {1'b0, s.ito}) begin
            o.rem = 16'(rn - {1'b0, s.ito});
            o.q   = {s.q[30:0], 1'b1};
        end else begin
            o.rem = rn[15:0];
            o.q   = {s.q[30:0], 1'b0};
        end
        return o;
    endfunction

    // rounded right shift, ties away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] x,
                                                input logic [5:0] sh);
        logic [63:0] m;
        logic [63:0] q;
        m = x[63] ? (~x + 64'd1) : x;
        q = (m + (64'd1 << (sh - 6'd1))) >> sh;
        return x[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// File: src/rrd_unitize.sv
module rrd_unitize (
    input  logic          i_clk,
    input  logic          i_en,
    input  rrd_pkg::t_vec i_vec,
    output rrd_pkg::t_vec o_unit
);

    typedef struct packed {
        logic [2:0]    sgn;
        logic          zero;
        rrd_pkg::t_vec m;
    } t_us;

    localparam int US_N = rrd_pkg::SQ_ST + 3;

    rrd_pkg::t_vec    r_mag;
    logic [2:0]       r_sgn;
    logic             r_zero;
    t_us              n_us0;
    t_us              r_us [US_N];
    logic [2:0][63:0] r_sqr;
    logic [63:0]      r_sum;
    rrd_pkg::t_sq     w_sq0;
    rrd_pkg::t_sq     r_sq [rrd_pkg::SQ_ST];
    rrd_pkg::t_dv     n_d0;
    rrd_pkg::t_dv     r_d0;
    rrd_pkg::t_dv     r_dv [rrd_pkg::DV_ST];
    rrd_pkg::t_vec    r_u;

    // shift all three up together until the largest reaches 2^30
    always_comb begin
        logic [31:0] top;
        int          sh;
        top = r_mag[0];
        if (r_mag[1] > top) top = r_mag[1];
        if (r_mag[2] > top) top = r_mag[2];
        n_us0.sgn  = r_sgn;
        n_us0.zero = r_zero;
        n_us0.m    = r_mag;
        for (int s = 0; s < 5; s++) begin
            sh = 16 >> s;
            if (top < (32'd1 << (31 - sh))) begin
                top = top << sh;
                for (int i = 0; i < 3; i++) begin
                    n_us0.m[i] = n_us0.m[i] << sh;
                end
            end
        end
    end

    assign w_sq0 = '{x: r_sum, r: '0, q: '0};

    always_comb begin
        logic [61:0] num;
        n_d0.len  = r_sq[rrd_pkg::SQ_ST-1].q;
        n_d0.sgn  = r_us[US_N-1].sgn;
        n_d0.zero = r_us[US_N-1].zero;
        for (int i = 0; i < 3; i++) begin
            num          = {r_us[US_N-1].m[i], 30'b0}
                         + {31'b0, r_sq[rrd_pkg::SQ_ST-1].q[31:1]};
            n_d0.rem[i]  = {2'b00, num[61:32]};
            n_d0.nl[i]   = num[31:0];
            n_d0.q[i]    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sgn[i] <= i_vec[i][31];
                r_mag[i] <= i_vec[i][31] ? (~i_vec[i] + 32'd1) : i_vec[i];
            end
            r_zero <= (i_vec == '0);
            r_us[0] <= n_us0;
            for (int k = 1; k < US_N; k++) begin
                r_us[k] <= r_us[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_sqr[i] <= r_us[0].m[i] * r_us[0].m[i];
            end
            r_sum <= r_sqr[0] + r_sqr[1] + r_sqr[2];
            r_sq[0] <= rrd_pkg::sqrt_step(rrd_pkg::sqrt_step(w_sq0));
            for (int k = 1; k < rrd_pkg::SQ_ST; k++) begin
                r_sq[k] <= rrd_pkg::sqrt_step(rrd_pkg::sqrt_step(r_sq[k-1]));
            end
            r_d0 <= n_d0;
            r_dv[0] <= rrd_pkg::div_step(rrd_pkg::div_step(r_d0));
            for (int k = 1; k < rrd_pkg::DV_ST; k++) begin
                r_dv[k] <= rrd_pkg::div_step(rrd_pkg::div_step(r_dv[k-1]));
            end
            for (int i = 0; i < 3; i++) begin
                if (r_dv[rrd_pkg::DV_ST-1].zero) begin
                    r_u[i] <= '0;
                end else if (r_dv[rrd_pkg::DV_ST-1].sgn[i]) begin
                    r_u[i] <= -r_dv[rrd_pkg::DV_ST-1].q[i];
                end else begin
                    r_u[i] <= r_dv[rrd_pkg::DV_ST-1].q[i];
                end
            end
        end
    end

    assign o_unit = r_u;

endmodule

// File: src/rrd_refract.sv
module rrd_refract (
    input  logic          i_clk,
    input  logic          i_en,
    input  rrd_pkg::t_vec i_du,
    input  rrd_pkg::t_vec i_nu,
    input  logic [20:0]   i_eta,
    output rrd_pkg::t_vec o_dir,
    output logic          o_tir
);

    typedef struct packed {
        rrd_pkg::t_vec      du;
        rrd_pkg::t_vec      nu;
        logic [20:0]        eta;
        logic [25:0]        r2;
        logic signed [63:0] rc;
        logic               tir;
    } t_side;

    localparam int SIDE_N = rrd_pkg::BACK_LAT - 1;
    localparam logic [56:0] ONE_Q46 = 57'd1 << 46;

    t_side              n_side [SIDE_N];
    t_side              r_side [SIDE_N];
    logic signed [63:0] r_p    [3];
    logic [41:0]        r_e2;
    logic signed [63:0] r_dot;
    logic signed [31:0] n_cosi;
    logic signed [31:0] r_cosi;
    logic signed [63:0] r_csq;
    logic [60:0]        w_omc;
    logic [30:0]        r_omc30;
    logic [56:0]        r_kq;
    logic [63:0]        r_x;
    rrd_pkg::t_sq       w_sq0;
    rrd_pkg::t_sq       r_sq   [rrd_pkg::SQ_ST];
    logic signed [63:0] r_c46;
    logic signed [31:0] r_c24;
    logic signed [63:0] r_cn   [3];
    logic signed [63:0] r_ed   [3];
    logic signed [63:0] r_t    [3];
    logic signed [63:0] r_ed2  [3];
    logic signed [63:0] r_acc  [3];
    rrd_pkg::t_vec      r_dir;
    logic               r_tir;

    // cosine: negated, rounded and clamped to unit range
    always_comb begin
        logic [63:0] dmag;
        logic [33:0] dq;
        logic [30:0] dqc;
        dmag   = r_dot[63] ? (~r_dot + 64'd1) : r_dot;
        dq     = 34'((dmag + 64'h2000_0000) >> 30);
        dqc    = (dq > 34'h4000_0000) ? 31'h4000_0000 : dq[30:0];
        n_cosi = r_dot[63] ? $signed({1'b0, dqc}) : -$signed({1'b0, dqc});
    end

    assign w_omc = 61'h1000_0000_0000_0000 - r_csq[60:0];
    assign w_sq0 = '{x: r_x, r: '0, q: '0};

    always_comb begin
        n_side[0] = '{du: i_du, nu: i_nu, eta: i_eta, r2: '0, rc: '0, tir: 1'b0};
        for (int k = 1; k < SIDE_N; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[1].r2  = 26'((r_e2 + 42'h8000) >> 16);
        n_side[3].rc  = $signed({1'b0, r_side[2].eta}) * r_cosi;
        n_side[6].tir = (r_kq > ONE_Q46);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= $signed(i_nu[i]) * $signed(i_du[i]);
            end
            r_e2    <= i_eta * i_eta;
            r_dot   <= r_p[0] + r_p[1] + r_p[2];
            r_cosi  <= n_cosi;
            r_csq   <= r_cosi * r_cosi;
            r_omc30 <= 31'((w_omc + 61'h2000_0000) >> 30);
            r_kq    <= r_side[4].r2 * r_omc30;
            r_x     <= {3'b000, 47'(ONE_Q46 - r_kq), 14'b0};
            r_sq[0] <= rrd_pkg::sqrt_step(rrd_pkg::sqrt_step(w_sq0));
            for (int k = 1; k < rrd_pkg::SQ_ST; k++) begin
                r_sq[k] <= rrd_pkg::sqrt_step(rrd_pkg::sqrt_step(r_sq[k-1]));
            end
            r_c46 <= r_side[22].rc
                   - $signed({16'b0, r_sq[rrd_pkg::SQ_ST-1].q, 16'b0});
            r_c24 <= 32'(rrd_pkg::rshr(r_c46, 6'd22));
            for (int i = 0; i < 3; i++) begin
                r_cn[i]  <= r_c24 * $signed(r_side[24].nu[i]);
                r_ed[i]  <= $signed({1'b0, r_side[24].eta}) * $signed(r_side[24].du[i]);
                r_t[i]   <= rrd_pkg::rshr(r_cn[i], 6'd8);
                r_ed2[i] <= r_ed[i];
                r_acc[i] <= r_ed2[i] + r_t[i];
                r_dir[i] <= r_side[SIDE_N-1].tir ? 32'd0
                                                 : 32'(rrd_pkg::rshr(r_acc[i], 6'd30));
            end
            r_tir <= r_side[SIDE_N-1].tir;
        end
    end

    assign o_dir = r_dir;
    assign o_tir = r_tir;

endmodule

// File: src/ray_refraction_direction_core.sv
// channel   handshake            payload
// input     i_valid / o_ready    i_dir_*, i_norm_*, i_hit_*, i_index_from, i_index_to
// output    o_valid / i_ready    o_origin_*, o_out_dir_*, o_total_reflection
//
// one item enters per cycle while o_ready is high
// latency is set by the two 32-step square roots and the 32-step unit division
// reset clears the valid bits, including those of the output and skid stages, not the data path
// a stalled output parks one item in the skid stage, then the whole pipeline holds
module ray_refraction_direction_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_norm_x,
    input  logic signed [31:0] i_norm_y,
    input  logic signed [31:0] i_norm_z,
    input  logic signed [31:0] i_hit_x,
    input  logic signed [31:0] i_hit_y,
    input  logic signed [31:0] i_hit_z,
    input  logic [15:0]        i_index_from,
    input  logic [15:0]        i_index_to,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_origin_x,
    output logic signed [31:0] o_origin_y,
    output logic signed [31:0] o_origin_z,
    output logic signed [31:0] o_out_dir_x,
    output logic signed [31:0] o_out_dir_y,
    output logic signed [31:0] o_out_dir_z,
    output logic               o_total_reflection
);

    localparam int PL = rrd_pkg::PIPE_LAT;
    localparam int ED = rrd_pkg::ETA_DLY;

    typedef struct packed {
        rrd_pkg::t_vec org;
        rrd_pkg::t_vec dir;
        logic          tir;
    } t_res;

    logic                        w_en;
    logic [PL-1:0]               r_vld;
    rrd_pkg::t_vec [PL-1:0]      r_hit;
    rrd_pkg::t_vec               w_du;
    rrd_pkg::t_vec               w_nu;
    rrd_pkg::t_vec               w_dir;
    logic                        w_tir;
    rrd_pkg::t_ed                r_e0;
    rrd_pkg::t_ed                r_ed [rrd_pkg::ETA_ST];
    logic [20:0]                 w_eta;
    logic [20:0]                 r_eta_s;
    logic [ED-1:0][20:0]         r_eta_d;
    t_res                        w_tail;
    t_res                        r_out;
    t_res                        r_skid;
    logic                        r_out_vld;
    logic                        r_skid_vld;

    assign w_en    = !r_skid_vld;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PL-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= {r_hit[PL-2:0], {i_hit_z, i_hit_y, i_hit_x}};
        end
    end

    rrd_unitize u_dir (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  ({i_dir_z, i_dir_y, i_dir_x}),
        .o_unit (w_du)
    );

    rrd_unitize u_norm (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  ({i_norm_z, i_norm_y, i_norm_x}),
        .o_unit (w_nu)
    );

    // index ratio, saturated, delayed to meet the unit vectors
    assign w_eta = (r_ed[rrd_pkg::ETA_ST-1].ito == 16'd0 ||
                    r_ed[rrd_pkg::ETA_ST-1].q > {11'b0, rrd_pkg::ETA_MAX})
                 ? rrd_pkg::ETA_MAX : r_ed[rrd_pkg::ETA_ST-1].q[20:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e0.rem <= '0;
            r_e0.n   <= {i_index_from, 16'h0} + {17'h0, i_index_to[15:1]};
            r_e0.q   <= '0;
            r_e0.ito <= i_index_to;
            r_ed[0]  <= rrd_pkg::eta_step(rrd_pkg::eta_step(r_e0));
            for (int k = 1; k < rrd_pkg::ETA_ST; k++) begin
                r_ed[k] <= rrd_pkg::eta_step(rrd_pkg::eta_step(r_ed[k-1]));
            end
            r_eta_s <= w_eta;
            r_eta_d <= {r_eta_d[ED-2:0], r_eta_s};
        end
    end

    rrd_refract u_refract (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_du  (w_du),
        .i_nu  (w_nu),
        .i_eta (r_eta_d[ED-1]),
        .o_dir (w_dir),
        .o_tir (w_tir)
    );

    assign w_tail = '{org: r_hit[PL-1], dir: w_dir, tir: w_tir};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || i_ready) begin
            r_out_vld <= r_vld[PL-1];
        end else if (r_vld[PL-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) r_out <= r_skid;
        end else if (!r_out_vld || i_ready) begin
            r_out <= w_tail;
        end else begin
            r_skid <= w_tail;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_origin_x         = $signed(r_out.org[0]);
    assign o_origin_y         = $signed(r_out.org[1]);
    assign o_origin_z         = $signed(r_out.org[2]);
    assign o_out_dir_x        = $signed(r_out.dir[0]);
    assign o_out_dir_y        = $signed(r_out.dir[1]);
    assign o_out_dir_z        = $signed(r_out.dir[2]);
    assign o_total_reflection = r_out.tir;

endmodule
